// ===== sv/cscan_pkg.sv =====
// ----------------------------------------------------------------------------
// cscan_pkg
// Shared types and constants for the C-SCAN disk request scheduler.
// ----------------------------------------------------------------------------
package cscan_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int TRACK_BITS_DEF  = 16;
    localparam int TAG_BITS_DEF    = 8;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_FREE,
        S_MIN,
        S_DRAIN,
        S_OUT
    } ctl_state_t;

    typedef enum logic [2:0] {
        K_DIRECT,
        K_FULL,
        K_QUEUE,
        K_MIN,
        K_NONE
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      set_kind;
        res_kind_t kind;
        logic      start_free;
        logic      scan_step;
        logic      start_min;
        logic      swap;
        logic      issue;
        logic      finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic op;
        logic busy;
        logic req_full;
        logic act_nonempty;
        logic oth_nonempty;
        logic free_hit;
        logic idx_last;
        logic out_free;
    } ctl_sts_t;

endpackage

// ===== sv/cscan_disk_request_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// cscan_disk_request_scheduler_unit
// C-SCAN disk head arbiter: grants requests in one-way sweep order.
// ----------------------------------------------------------------------------
// Results: a grant to an idle disk, a dropped request or a release with nothing
//   waiting need no scan before the result is loaded; a queued request first
//   runs a free-slot scan (one slot per cycle); a release grant first runs a
//   minimum-track scan over every slot through the table RAM read port.
// Throughput: one request at a time; next accepted once the result is loaded.
// Reset: tables empty (valid bits cleared at once), head 0, idle, table a.
// ----------------------------------------------------------------------------
module cscan_disk_request_scheduler_unit
    import cscan_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int TRACK_BITS  = TRACK_BITS_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int S_DATA_W    = ((TRACK_BITS + TAG_BITS + 7) / 8) * 8,
    parameter int M_DATA_W    = ((TRACK_BITS + TAG_BITS + 2 + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // track, requester_tag
    input  logic                s_tuser,   // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // grant_tag, grant_track, table_full, disk_busy
    output logic                m_tuser    // grant_valid
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    cscan_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cscan_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TRACK_BITS  (TRACK_BITS),
        .TAG_BITS    (TAG_BITS),
        .S_DATA_W    (S_DATA_W),
        .M_DATA_W    (M_DATA_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in progress");

    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata[TAG_BITS + TRACK_BITS + 1])
        else $error("grant reported with disk idle");

    a_full_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[TAG_BITS + TRACK_BITS]) |->
        (!m_tuser && m_tdata[TAG_BITS + TRACK_BITS + 1]))
        else $error("table full with grant or idle disk");

    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !cmd.load && !cmd.issue)
        else $error("finish overlaps load or scan");

endmodule

// ===== sv/cscan_ram.sv =====
// ----------------------------------------------------------------------------
// cscan_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cscan_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cscan_ctrl.sv =====
// ----------------------------------------------------------------------------
// cscan_ctrl
// Sequencer: decodes a request, runs free-slot and minimum-track scans.
// ----------------------------------------------------------------------------
module cscan_ctrl
    import cscan_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = K_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.set_kind = 1'b1;
                if (sts.op == OP_REQUEST)
                begin
                    if (!sts.busy)
                    begin
                        cmd.kind   = K_DIRECT;
                        state_next = S_OUT;
                    end
                    else if (sts.req_full)
                    begin
                        cmd.kind   = K_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.kind       = K_QUEUE;
                        cmd.start_free = 1'b1;
                        state_next     = S_FREE;
                    end
                end
                else
                begin
                    if (sts.act_nonempty)
                    begin
                        cmd.kind      = K_MIN;
                        cmd.start_min = 1'b1;
                        state_next    = S_MIN;
                    end
                    else if (sts.oth_nonempty)
                    begin
                        cmd.kind      = K_MIN;
                        cmd.start_min = 1'b1;
                        cmd.swap      = 1'b1;
                        state_next    = S_MIN;
                    end
                    else
                    begin
                        cmd.kind   = K_NONE;
                        state_next = S_OUT;
                    end
                end
            end
            S_FREE:
            begin
                if (sts.free_hit)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MIN:
            begin
                cmd.issue = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/cscan_dp.sv =====
// ----------------------------------------------------------------------------
// cscan_dp
// Datapath: sweep tables, head/busy state, scan registers, result register.
// ----------------------------------------------------------------------------
module cscan_dp
    import cscan_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int TRACK_BITS  = TRACK_BITS_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int S_DATA_W    = ((TRACK_BITS + TAG_BITS + 7) / 8) * 8,
    parameter int M_DATA_W    = ((TRACK_BITS + TAG_BITS + 2 + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  ctl_cmd_t            cmd,
    output ctl_sts_t            sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser
);

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W     = TRACK_BITS + TAG_BITS;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    logic                        op_reg;
    logic [TRACK_BITS-1:0]       trk_reg;
    logic [TAG_BITS-1:0]         tag_reg;
    logic [TRACK_BITS-1:0]       head_reg;
    logic                        busy_reg;
    logic                        active_reg;
    logic [1:0][TABLE_DEPTH-1:0] valid_reg;
    logic [1:0][CNT_W-1:0]       cnt_reg;
    logic                        tbl_reg;
    logic [IDX_W-1:0]            idx_reg;
    res_kind_t                   kind_reg;
    logic                        rd_pend_reg;
    logic                        rd_vld_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic                        found_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [TRACK_BITS-1:0]       best_trk_reg;
    logic [TAG_BITS-1:0]         best_tag_reg;
    logic                        out_valid_reg;
    logic                        out_gv_reg;
    logic [TAG_BITS-1:0]         out_tag_reg;
    logic [TRACK_BITS-1:0]       out_trk_reg;
    logic                        out_full_reg;
    logic                        out_busy_reg;

    logic                        which;
    logic                        out_free;
    logic                        ram_we;
    logic [ENT_W-1:0]            ram_rdata;
    logic [TRACK_BITS-1:0]       rd_trk;
    logic [TAG_BITS-1:0]         rd_tag;
    logic                        better;

    assign which    = active_reg ^ (trk_reg < head_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign ram_we   = cmd.finish && (kind_reg == K_QUEUE);
    assign rd_trk   = ram_rdata[TRACK_BITS-1:0];
    assign rd_tag   = ram_rdata[ENT_W-1 -: TAG_BITS];
    assign better   = rd_pend_reg && rd_vld_reg && (!found_reg || (rd_trk < best_trk_reg));

    cscan_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({tbl_reg, idx_reg}),
        .wdata ({tag_reg, trk_reg}),
        .raddr ({tbl_reg, idx_reg}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.op           = op_reg;
        sts.busy         = busy_reg;
        sts.req_full     = (cnt_reg[which] == CNT_W'(TABLE_DEPTH));
        sts.act_nonempty = (cnt_reg[active_reg] != '0);
        sts.oth_nonempty = (cnt_reg[~active_reg] != '0);
        sts.free_hit     = !valid_reg[tbl_reg][idx_reg];
        sts.idx_last     = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
        sts.out_free     = out_free;
    end

    // item payload and scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= s_tuser;
            trk_reg <= s_tdata[TRACK_BITS-1:0];
            tag_reg <= s_tdata[ENT_W-1 -: TAG_BITS];
        end
        if (cmd.start_free)
        begin
            tbl_reg <= which;
            idx_reg <= '0;
        end
        else if (cmd.start_min)
        begin
            tbl_reg <= cmd.swap ? ~active_reg : active_reg;
            idx_reg <= '0;
        end
        else if (cmd.scan_step || cmd.issue)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        rd_idx_reg <= idx_reg;
        rd_vld_reg <= valid_reg[tbl_reg][idx_reg];
        if (better)
        begin
            best_idx_reg <= rd_idx_reg;
            best_trk_reg <= rd_trk;
            best_tag_reg <= rd_tag;
        end
        if (cmd.finish)
        begin
            out_gv_reg   <= (kind_reg == K_DIRECT) || (kind_reg == K_MIN);
            out_full_reg <= (kind_reg == K_FULL);
            out_busy_reg <= (kind_reg != K_NONE);
            case (kind_reg)
                K_DIRECT:
                begin
                    out_tag_reg <= tag_reg;
                    out_trk_reg <= trk_reg;
                end
                K_MIN:
                begin
                    out_tag_reg <= best_tag_reg;
                    out_trk_reg <= best_trk_reg;
                end
                default:
                begin
                    out_tag_reg <= '0;
                    out_trk_reg <= '0;
                end
            endcase
        end
    end

    // scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            busy_reg      <= 1'b0;
            active_reg    <= 1'b0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            kind_reg      <= K_NONE;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.issue;
            if (cmd.set_kind)
            begin
                kind_reg <= cmd.kind;
            end
            if (cmd.start_min)
            begin
                found_reg <= 1'b0;
                if (cmd.swap)
                begin
                    active_reg <= ~active_reg;
                end
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                case (kind_reg)
                    K_DIRECT:
                    begin
                        busy_reg <= 1'b1;
                        head_reg <= trk_reg;
                    end
                    K_QUEUE:
                    begin
                        valid_reg[tbl_reg][idx_reg] <= 1'b1;
                        cnt_reg[tbl_reg]            <= cnt_reg[tbl_reg] + 1'b1;
                    end
                    K_MIN:
                    begin
                        valid_reg[tbl_reg][best_idx_reg] <= 1'b0;
                        cnt_reg[tbl_reg]                 <= cnt_reg[tbl_reg] - 1'b1;
                        head_reg                         <= best_trk_reg;
                    end
                    K_NONE:
                    begin
                        busy_reg <= 1'b0;
                    end
                    default:
                    begin
                        busy_reg <= busy_reg;
                    end
                endcase
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_gv_reg;
    assign m_tdata  = M_DATA_W'({out_busy_reg, out_full_reg, out_trk_reg, out_tag_reg});

endmodule
